// File: hw/rtl/afb_pkg.sv
package afb_pkg;

   // geometry defaults
   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   // field widths
   localparam int CMD_W      = 3;
   localparam int COORD_W    = 12;
   localparam int DIM_W      = 9;
   localparam int PIX_W      = 32;
   localparam int DEPTH_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // commands
   localparam logic [CMD_W-1:0] CMD_PLOT  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 3'd2;
   localparam logic [CMD_W-1:0] CMD_PUSH  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_POP   = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DRAW_COLOR   = 2'd2;

   // reset values
   localparam logic [DIM_W-1:0]   FRAME_DIM_RESET = 9'd256;
   localparam logic [PIX_W-1:0]   COLOR_RESET     = 32'hFFC8_C8C8;
   localparam logic [PIX_W-1:0]   BASE_RESET      = 32'hFF1E_1E1E;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX       = 8'd255;

   // controller to datapath commands
   typedef struct packed {
      logic fill_base;    // write fill value into base store
      logic fill_ovl;     // write fill value into overlay store
      logic fill_clear;   // fill with reset values instead of draw color
      logic blend;        // start a read-blend-write of a base pixel
      logic blend_ovl;    // blend source is the overlay pixel, else draw color
      logic rd;           // read both stores into the read registers
      logic rsp_load;     // load the pixel result register
      logic rsp_pix_en;   // result carries a read pixel
      logic rsp_pix_ovl;  // read pixel comes from the overlay
   } dp_cmd_type;

endpackage

// File: hw/rtl/afb_req_if.sv
interface afb_req_if;
   logic                              valid;
   logic                              ready;
   logic [afb_pkg::CMD_W-1:0]         cmd;
   logic signed [afb_pkg::COORD_W-1:0] x_pos;
   logic signed [afb_pkg::COORD_W-1:0] y_pos;

   modport source (output valid, output cmd, output x_pos, output y_pos, input ready);
   modport sink   (input valid, input cmd, input x_pos, input y_pos, output ready);
endinterface

// File: hw/rtl/afb_rsp_if.sv
interface afb_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [afb_pkg::PIX_W-1:0]   pixel_value;
   logic                        in_range;
   logic [afb_pkg::DEPTH_W-1:0] layer_depth;

   modport source (output valid, output pixel_value, output in_range, output layer_depth,
                   input ready);
   modport sink   (input valid, input pixel_value, input in_range, input layer_depth,
                   output ready);
endinterface

// File: hw/rtl/afb_datapath.sv
module afb_datapath #(
   parameter int MAX_WIDTH  = afb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = afb_pkg::DEF_MAX_HEIGHT,
   parameter int DEPTH      = MAX_WIDTH * MAX_HEIGHT,
   parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  afb_pkg::dp_cmd_type       cmd,
   input  logic [AW-1:0]             addr,
   input  logic [afb_pkg::PIX_W-1:0] draw_color,
   output logic                      busy,
   output logic [afb_pkg::PIX_W-1:0] pixel_value
);

   // exact floor(v / 255) for v up to 255*255
   function automatic logic [7:0] div255(input logic [15:0] v);
      logic [15:0] t;
      t = v + 16'd1 + {8'd0, v[15:8]};
      return t[15:8];
   endfunction

   logic [afb_pkg::PIX_W-1:0] base_mem [DEPTH];
   logic [afb_pkg::PIX_W-1:0] ovl_mem  [DEPTH];

   logic [afb_pkg::PIX_W-1:0] base_q_ff;
   logic [afb_pkg::PIX_W-1:0] ovl_q_ff;

   // stage 1: read data present
   logic                      s1_valid_ff, s1_valid_in;
   logic                      s1_ovl_ff;
   logic [AW-1:0]             s1_addr_ff;

   // stage 2: products registered
   logic                      s2_valid_ff, s2_valid_in;
   logic [AW-1:0]             s2_addr_ff;
   logic [15:0]               s2_sum_ff [3];
   logic [15:0]               s2_sum_in [3];
   logic [15:0]               s2_balpha_ff, s2_balpha_in;
   logic [7:0]                s2_alpha_ff, s2_alpha_in;

   logic [afb_pkg::PIX_W-1:0] pixel_ff, pixel_in;
   logic [afb_pkg::PIX_W-1:0] src_pix;
   logic [afb_pkg::PIX_W-1:0] blend_pix;
   logic [afb_pkg::PIX_W-1:0] fill_base_val;
   logic [afb_pkg::PIX_W-1:0] fill_ovl_val;
   logic [7:0]                inv_alpha;

   assign s1_valid_in = cmd.blend;
   assign s2_valid_in = s1_valid_ff;
   assign busy        = s1_valid_ff | s2_valid_ff;

   always_comb begin
      src_pix      = s1_ovl_ff ? ovl_q_ff : draw_color;
      s2_alpha_in  = src_pix[31:24];
      inv_alpha    = 8'd255 - src_pix[31:24];
      for (int i = 0; i < 3; i++) begin
         s2_sum_in[i] = 16'(src_pix[8*i +: 8]) * 16'(s2_alpha_in)
                      + 16'(base_q_ff[8*i +: 8]) * 16'(inv_alpha);
      end
      s2_balpha_in = 16'(base_q_ff[31:24]) * 16'(inv_alpha);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         blend_pix[8*i +: 8] = div255(s2_sum_ff[i]);
      end
      blend_pix[31:24] = s2_alpha_ff + div255(s2_balpha_ff);
   end

   assign fill_base_val = cmd.fill_clear ? afb_pkg::BASE_RESET : draw_color;
   assign fill_ovl_val  = cmd.fill_clear ? '0 : draw_color;

   always_comb begin
      pixel_in = pixel_ff;
      if (cmd.rsp_load) begin
         if (!cmd.rsp_pix_en) begin
            pixel_in = '0;
         end else begin
            pixel_in = cmd.rsp_pix_ovl ? ovl_q_ff : base_q_ff;
         end
      end
   end

   // base store: blend write-back or fill
   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         base_mem[s2_addr_ff] <= blend_pix;
      end else if (cmd.fill_base) begin
         base_mem[addr] <= fill_base_val;
      end
      if (cmd.blend || cmd.rd) begin
         base_q_ff <= base_mem[addr];
      end
   end

   // overlay store
   always_ff @(posedge clock) begin
      if (cmd.fill_ovl) begin
         ovl_mem[addr] <= fill_ovl_val;
      end
      if (cmd.blend || cmd.rd) begin
         ovl_q_ff <= ovl_mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ovl_ff    <= cmd.blend_ovl;
      s1_addr_ff   <= addr;
      s2_addr_ff   <= s1_addr_ff;
      s2_sum_ff    <= s2_sum_in;
      s2_balpha_ff <= s2_balpha_in;
      s2_alpha_ff  <= s2_alpha_in;
      pixel_ff     <= pixel_in;
   end

   assign pixel_value = pixel_ff;

endmodule

// File: hw/rtl/afb_ctrl.sv
module afb_ctrl #(
   parameter int MAX_WIDTH  = afb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = afb_pkg::DEF_MAX_HEIGHT,
   parameter int DEPTH      = MAX_WIDTH * MAX_HEIGHT,
   parameter int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [afb_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [afb_pkg::COORD_W-1:0] req_x_pos,
   input  logic signed [afb_pkg::COORD_W-1:0] req_y_pos,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_in_range,
   output logic [afb_pkg::DEPTH_W-1:0]        rsp_layer_depth,
   input  logic [afb_pkg::DIM_W-1:0]          frame_width,
   input  logic [afb_pkg::DIM_W-1:0]          frame_height,
   output afb_pkg::dp_cmd_type                dp_cmd,
   output logic [AW-1:0]                      dp_addr,
   input  logic                               dp_busy
);

   localparam int CW  = afb_pkg::COORD_W;
   localparam int ACW = 2 * afb_pkg::COORD_W;

   localparam logic [2:0] ST_INIT   = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_DECODE = 3'd2;
   localparam logic [2:0] ST_SWEEP  = 3'd3;
   localparam logic [2:0] ST_LINEAR = 3'd4;
   localparam logic [2:0] ST_DRAIN  = 3'd5;
   localparam logic [2:0] ST_RESP   = 3'd6;

   localparam logic [CW-1:0] MAX_W_L = CW'(MAX_WIDTH);
   localparam logic [CW-1:0] MAX_H_L = CW'(MAX_HEIGHT);

   logic [2:0]                   state_ff, state_in;
   logic [afb_pkg::DEPTH_W-1:0]  nest_ff, nest_in;
   logic [afb_pkg::CMD_W-1:0]    item_cmd_ff, item_cmd_in;
   logic signed [CW-1:0]         item_x_ff, item_x_in;
   logic signed [CW-1:0]         item_y_ff, item_y_in;
   logic [AW-1:0]                addr_ff, addr_in;
   logic [AW-1:0]                row_ff, row_in;
   logic [CW-1:0]                xcnt_ff, xcnt_in;
   logic [CW-1:0]                ycnt_ff, ycnt_in;
   logic                         merge_ff, merge_in;
   logic                         sweep_ovl_ff, sweep_ovl_in;
   logic                         rng_ff, rng_in;
   logic                         pix_en_ff, pix_en_in;
   logic                         pix_ovl_ff, pix_ovl_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_range_ff, rsp_range_in;
   logic [afb_pkg::DEPTH_W-1:0]  rsp_depth_ff, rsp_depth_in;

   logic [CW-1:0]  eff_w;
   logic [CW-1:0]  eff_h;
   logic           frame_empty;
   logic           coord_in_frame;
   logic [ACW-1:0] item_lin;
   logic [AW-1:0]  item_addr;
   logic           row_end;
   logic           sweep_last;
   logic           lin_last;

   // frame size clamped to the store geometry
   always_comb begin
      eff_w = ({3'd0, frame_width} > MAX_W_L) ? MAX_W_L : CW'(frame_width);
      eff_h = ({3'd0, frame_height} > MAX_H_L) ? MAX_H_L : CW'(frame_height);
   end

   assign frame_empty = (eff_w == '0) || (eff_h == '0);
   assign coord_in_frame = !item_x_ff[CW-1] && !item_y_ff[CW-1]
                && ($unsigned(item_x_ff) < eff_w) && ($unsigned(item_y_ff) < eff_h);
   assign item_lin = {{CW{1'b0}}, item_y_ff} * ACW'(MAX_WIDTH)
                   + {{CW{1'b0}}, item_x_ff};
   assign item_addr = item_lin[AW-1:0];

   assign row_end    = (xcnt_ff == eff_w - CW'(1));
   assign sweep_last = row_end && (ycnt_ff == eff_h - CW'(1));
   assign lin_last   = (addr_ff == AW'(DEPTH - 1));

   always_comb begin
      state_in     = state_ff;
      nest_in      = nest_ff;
      item_cmd_in  = item_cmd_ff;
      item_x_in    = item_x_ff;
      item_y_in    = item_y_ff;
      addr_in      = addr_ff;
      row_in       = row_ff;
      xcnt_in      = xcnt_ff;
      ycnt_in      = ycnt_ff;
      merge_in     = merge_ff;
      sweep_ovl_in = sweep_ovl_ff;
      rng_in       = rng_ff;
      pix_en_in    = pix_en_ff;
      pix_ovl_in   = pix_ovl_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_range_in = rsp_range_ff;
      rsp_depth_in = rsp_depth_ff;
      dp_cmd       = '0;
      req_ready    = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_INIT: begin
            // power-up clear of both stores
            dp_cmd.fill_base  = 1'b1;
            dp_cmd.fill_ovl   = 1'b1;
            dp_cmd.fill_clear = 1'b1;
            addr_in = addr_ff + AW'(1);
            if (lin_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_cmd_in = req_cmd;
               item_x_in   = req_x_pos;
               item_y_in   = req_y_pos;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            rng_in     = 1'b0;
            pix_en_in  = 1'b0;
            pix_ovl_in = (nest_ff != '0);
            state_in   = ST_RESP;
            xcnt_in    = '0;
            ycnt_in    = '0;
            addr_in    = '0;
            row_in     = '0;
            unique case (item_cmd_ff)
               afb_pkg::CMD_PLOT: begin
                  if (coord_in_frame) begin
                     rng_in = 1'b1;
                     if (nest_ff != '0) begin
                        dp_cmd.fill_ovl = 1'b1;
                     end else begin
                        dp_cmd.blend = 1'b1;
                        state_in     = ST_DRAIN;
                     end
                  end
               end
               afb_pkg::CMD_READ: begin
                  if (coord_in_frame) begin
                     rng_in    = 1'b1;
                     pix_en_in = 1'b1;
                     dp_cmd.rd = 1'b1;
                  end
               end
               afb_pkg::CMD_CLEAR: begin
                  merge_in     = 1'b0;
                  sweep_ovl_in = (nest_ff != '0);
                  if (!frame_empty) begin
                     state_in = ST_SWEEP;
                  end
               end
               afb_pkg::CMD_PUSH: begin
                  if (nest_ff == '0) begin
                     // first layer starts from an empty overlay
                     nest_in  = afb_pkg::DEPTH_W'(1);
                     state_in = ST_LINEAR;
                  end else if (nest_ff != afb_pkg::DEPTH_MAX) begin
                     nest_in = nest_ff + afb_pkg::DEPTH_W'(1);
                  end
               end
               afb_pkg::CMD_POP: begin
                  if (nest_ff > afb_pkg::DEPTH_W'(1)) begin
                     nest_in = nest_ff - afb_pkg::DEPTH_W'(1);
                  end else if (nest_ff == afb_pkg::DEPTH_W'(1)) begin
                     // closing the last layer merges the overlay onto the base
                     nest_in  = '0;
                     merge_in = 1'b1;
                     if (!frame_empty) begin
                        state_in = ST_SWEEP;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SWEEP: begin
            if (merge_ff) begin
               dp_cmd.blend     = 1'b1;
               dp_cmd.blend_ovl = 1'b1;
            end else begin
               dp_cmd.fill_base = !sweep_ovl_ff;
               dp_cmd.fill_ovl  = sweep_ovl_ff;
            end
            if (row_end) begin
               xcnt_in = '0;
               ycnt_in = ycnt_ff + CW'(1);
               row_in  = row_ff + AW'(MAX_WIDTH);
               addr_in = row_ff + AW'(MAX_WIDTH);
            end else begin
               xcnt_in = xcnt_ff + CW'(1);
               addr_in = addr_ff + AW'(1);
            end
            if (sweep_last) begin
               state_in = merge_ff ? ST_DRAIN : ST_RESP;
            end
         end
         ST_LINEAR: begin
            dp_cmd.fill_ovl   = 1'b1;
            dp_cmd.fill_clear = 1'b1;
            addr_in = addr_ff + AW'(1);
            if (lin_last) begin
               state_in = ST_RESP;
            end
         end
         ST_DRAIN: begin
            if (!dp_busy) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_range_in       = rng_ff;
               rsp_depth_in       = nest_ff;
               dp_cmd.rsp_load    = 1'b1;
               dp_cmd.rsp_pix_en  = pix_en_ff;
               dp_cmd.rsp_pix_ovl = pix_ovl_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign dp_addr = (state_ff == ST_DECODE) ? item_addr : addr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         nest_ff      <= '0;
         addr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         nest_ff      <= nest_in;
         addr_ff      <= addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_cmd_ff  <= item_cmd_in;
      item_x_ff    <= item_x_in;
      item_y_ff    <= item_y_in;
      row_ff       <= row_in;
      xcnt_ff      <= xcnt_in;
      ycnt_ff      <= ycnt_in;
      merge_ff     <= merge_in;
      sweep_ovl_ff <= sweep_ovl_in;
      rng_ff       <= rng_in;
      pix_en_ff    <= pix_en_in;
      pix_ovl_ff   <= pix_ovl_in;
      rsp_range_ff <= rsp_range_in;
      rsp_depth_ff <= rsp_depth_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_in_range    = rsp_range_ff;
   assign rsp_layer_depth = rsp_depth_ff;

   // result only once all blend write-backs have landed
   assert property (@(posedge clock) disable iff (reset) dp_cmd.rsp_load |-> !dp_busy)
      else $error("result loaded with blend still in flight");

   // base store write port is never claimed by a fill and a write-back at once
   assert property (@(posedge clock) disable iff (reset) dp_cmd.fill_base |-> !dp_busy)
      else $error("base fill collides with blend write-back");

   // nesting level only moves while a command is decoded
   assert property (@(posedge clock) disable iff (reset)
                    (state_ff != ST_DECODE) |=> $stable(nest_ff))
      else $error("layer depth changed outside decode");

   // a new item never enters while the pipeline still holds work
   assert property (@(posedge clock) disable iff (reset)
                    (req_valid && req_ready) |-> !dp_busy)
      else $error("item accepted with datapath busy");

endmodule

// File: hw/rtl/alpha_blend_framebuffer_engine.sv
// alpha blending framebuffer engine
// req_if carries commands (plot, read, clear, push layer, pop layer) with a signed
// x/y coordinate; rsp_if returns one item per command with the read pixel, the
// in-range flag and the layer depth after the command. csr_* writes the frame
// size and draw color; write only while no command is in progress.
// after reset a clearing pass runs over all MAX_WIDTH*MAX_HEIGHT addresses of
// both stores; req_if.ready stays low until it ends. states per command:
//   read, plot in a layer, out-of-range plot, nested push/pop: decode, response
//   plot onto the base store: decode, drain of the read, multiply, divide,
//   write-back pipeline, response
//   clear: width*height sweep; final pop: width*height merge sweep, drain; first
//   push: MAX_WIDTH*MAX_HEIGHT clear; one write port per store sets the sweeps
// one command is in flight at a time; the response sits in an output register,
// so the next item is taken while it waits. if rsp_if.ready stays low, the
// following command completes and then holds until the first result is taken.
module alpha_blend_framebuffer_engine #(
   parameter int MAX_WIDTH  = afb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = afb_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   afb_req_if.sink                             req_if,
   afb_rsp_if.source                           rsp_if,
   input  logic                                csr_wr_en,
   input  logic [afb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [afb_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // configuration registers
   logic [afb_pkg::DIM_W-1:0] frame_width_ff, frame_width_in;
   logic [afb_pkg::DIM_W-1:0] frame_height_ff, frame_height_in;
   logic [afb_pkg::PIX_W-1:0] draw_color_ff, draw_color_in;

   afb_pkg::dp_cmd_type dp_cmd;
   logic [AW-1:0]       dp_addr;
   logic                dp_busy;

   // register decode, unknown indexes are dropped
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      draw_color_in   = draw_color_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            afb_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_wr_data[afb_pkg::DIM_W-1:0];
            afb_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_wr_data[afb_pkg::DIM_W-1:0];
            afb_pkg::CSR_DRAW_COLOR:   draw_color_in   = csr_wr_data[afb_pkg::PIX_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= afb_pkg::FRAME_DIM_RESET;
         frame_height_ff <= afb_pkg::FRAME_DIM_RESET;
         draw_color_ff   <= afb_pkg::COLOR_RESET;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         draw_color_ff   <= draw_color_in;
      end
   end

   // command sequencing, sweeps and result handshake
   afb_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .DEPTH      (DEPTH),
      .AW         (AW)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_if.valid),
      .req_ready       (req_if.ready),
      .req_cmd         (req_if.cmd),
      .req_x_pos       (req_if.x_pos),
      .req_y_pos       (req_if.y_pos),
      .rsp_valid       (rsp_if.valid),
      .rsp_ready       (rsp_if.ready),
      .rsp_in_range    (rsp_if.in_range),
      .rsp_layer_depth (rsp_if.layer_depth),
      .frame_width     (frame_width_ff),
      .frame_height    (frame_height_ff),
      .dp_cmd          (dp_cmd),
      .dp_addr         (dp_addr),
      .dp_busy         (dp_busy)
   );

   // pixel stores and blend pipeline
   afb_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT),
      .DEPTH      (DEPTH),
      .AW         (AW)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (dp_cmd),
      .addr        (dp_addr),
      .draw_color  (draw_color_ff),
      .busy        (dp_busy),
      .pixel_value (rsp_if.pixel_value)
   );

endmodule
